/* rtl/assert_macros.svh */
// Assertion helpers, sampled on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds in the same cycle.
`define SPMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Holds in the following cycle.
`define SPMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spma_pkg.sv */
package spma_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int PCT_W      = 7;
    localparam int FIX_W      = 15;
    localparam int DVD_W      = SAMPLE_W + FIX_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int WINDOW_LENGTH_DEF = 10;

    localparam logic [FIX_W-1:0] FULL_SCALE = 15'd25600;
    localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;

    localparam logic [SAMPLE_W-1:0] CLEAN_RST = 10'd900;
    localparam logic [SAMPLE_W-1:0] DIRTY_RST = 10'd40;
    localparam logic [PCT_W-1:0]    DELTA_RST = 7'd10;
    localparam logic [PCT_W-1:0]    ALARM_RST = 7'd20;

    localparam logic [CFG_IDX_W-1:0] REG_CLEAN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRTY = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM = 8'd3;

    // quotient bits of the percent division
    localparam logic [3:0] PCT_STEPS  = 4'd15;

    typedef struct packed {
        logic       hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // v is at most 100
    function automatic digits_t to_digits(input logic [PCT_W-1:0] v);
        digits_t    d;
        logic [PCT_W-1:0] r;
        logic [3:0] t;
        logic [PCT_W-1:0] tr;
        d.hundreds = (v >= PCT_MAX);
        r = d.hundreds ? (v - PCT_MAX) : v;
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= PCT_W'(10 * k)) begin
                t = 4'(k);
            end
        end
        tr = r - PCT_W'({3'd0, t} * 7'd10);
        d.tens  = t;
        d.units = tr[3:0];
        return d;
    endfunction

endpackage

/* rtl/sensor_percent_moving_average.sv */
// Channel | Dir | Handshake         | Payload (low bit first)
// s       | in  | s_tvalid/s_tready | s_tdata: adc_sample[9:0], zero pad
// m       | out | m_tvalid/m_tready | m_tdata: level, hundreds, tens, units, save, alarm
// cfg     | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// A request whose sample lies between the levels passes through setup, the radix-2
// percent divider (load plus 15 steps), then ring update, reciprocal-multiply mean
// and output, in that order.
// Samples outside the span skip the divider.
// Reset clears the ring through per-entry valid bits; no clearing pass.
// A finished result waits in the output register; the next request is taken meanwhile
// and its result holds in S_DONE until the register frees.
module sensor_percent_moving_average
    import spma_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] adc_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [6:0] level_percent, [7] digit_hundreds, [11:8] digit_tens,
    // [15:12] digit_units, [16] save_request, [17] replace_alarm
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW        = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int TOTAL_MAX = WINDOW_LENGTH * 25600;
    localparam int TOTAL_W   = $clog2(TOTAL_MAX + 1);
    localparam logic [TOTAL_W-1:0] TOTAL_LIM = TOTAL_W'(TOTAL_MAX);

    // mean = (total >> 8) / WINDOW_LENGTH, exact while (total >> 8) <= 100 * WINDOW_LENGTH
    localparam int AVG_W      = TOTAL_W - 8;
    localparam int MEAN_SHIFT = 19;
    localparam int MEAN_RECIP = ((1 << MEAN_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int MPROD_W    = AVG_W + MEAN_SHIFT + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_UPD,
        S_MEAN,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [FIX_W-1:0]      old_reg;
    logic [FIX_W-1:0]      pct_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [AW-1:0]         wpos_reg;
    logic [WINDOW_LENGTH-1:0] valid_reg;
    logic [PCT_W-1:0]      saved_reg;
    logic [DVD_W-1:0]      prod_reg;
    logic [SAMPLE_W-1:0]   div_rem_reg;
    logic [FIX_W-1:0]      div_dvd_reg;
    logic [SAMPLE_W-1:0]   div_sor_reg;
    logic [3:0]            div_cnt_reg;
    logic [PCT_W-1:0]      mean_reg;

    logic [SAMPLE_W-1:0]   clean_reg;
    logic [SAMPLE_W-1:0]   dirty_reg;
    logic [PCT_W-1:0]      delta_reg;
    logic [PCT_W-1:0]      alarm_reg;

    logic                  m_valid_reg;
    logic [PCT_W-1:0]      level_reg;
    digits_t               digits_reg;
    logic                  save_reg;
    logic                  alarm_out_reg;

    logic [FIX_W-1:0]      mem [WINDOW_LENGTH];
    logic [FIX_W-1:0]      rd_data_reg;

    // divider step
    logic [SAMPLE_W:0]     trial;
    logic                  trial_ge;
    logic [SAMPLE_W-1:0]   rem_next;
    logic [FIX_W-1:0]      dvd_next;

    logic [TOTAL_W-1:0]    total_next;
    logic [AVG_W-1:0]      avg_base;
    logic [MPROD_W-1:0]    mean_prod;
    logic [PCT_W-1:0]      mean_calc;
    logic [PCT_W-1:0]      mean_diff;
    logic                  save_now;
    logic                  accept;
    logic                  out_free;

    logic [7:0]            out_digit_sum;
    logic                  digits_ok;
    logic                  div_stepping;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, alarm_out_reg, save_reg, digits_reg.units, digits_reg.tens,
                       digits_reg.hundreds, level_reg};

    assign trial    = {div_rem_reg, div_dvd_reg[FIX_W-1]};
    assign trial_ge = (trial >= {1'b0, div_sor_reg});
    assign rem_next = trial_ge ? SAMPLE_W'(trial - {1'b0, div_sor_reg}) : trial[SAMPLE_W-1:0];
    assign dvd_next = {div_dvd_reg[FIX_W-2:0], trial_ge};

    assign total_next = total_reg - TOTAL_W'(old_reg) + TOTAL_W'(pct_reg);
    assign avg_base   = total_reg[TOTAL_W-1:8];
    assign mean_prod  = MPROD_W'(avg_base) * MPROD_W'(MEAN_RECIP);
    assign mean_calc  = mean_prod[MEAN_SHIFT +: PCT_W];
    assign mean_diff  = (mean_reg > saved_reg) ? (mean_reg - saved_reg) : (saved_reg - mean_reg);
    assign save_now   = (mean_diff > delta_reg);

    assign out_digit_sum = {7'd0, m_tdata[7]} * 8'd100 + {4'd0, m_tdata[11:8]} * 8'd10
                           + {4'd0, m_tdata[15:12]};
    assign digits_ok     = ({1'b0, m_tdata[6:0]} == out_digit_sum);
    assign div_stepping  = (state_reg == S_DIV) && (div_cnt_reg != PCT_STEPS - 4'd1);

    always_ff @(posedge clk) begin
        if (state_reg == S_UPD) begin
            mem[wpos_reg] <= pct_reg;
        end
        rd_data_reg <= mem[wpos_reg];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            sample_reg    <= '0;
            old_reg       <= '0;
            pct_reg       <= '0;
            total_reg     <= '0;
            wpos_reg      <= '0;
            valid_reg     <= '0;
            saved_reg     <= '0;
            prod_reg      <= '0;
            div_rem_reg   <= '0;
            div_dvd_reg   <= '0;
            div_sor_reg   <= '0;
            div_cnt_reg   <= '0;
            mean_reg      <= '0;
            clean_reg     <= CLEAN_RST;
            dirty_reg     <= DIRTY_RST;
            delta_reg     <= DELTA_RST;
            alarm_reg     <= ALARM_RST;
            m_valid_reg   <= 1'b0;
            level_reg     <= '0;
            digits_reg    <= '0;
            save_reg      <= 1'b0;
            alarm_out_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CLEAN: clean_reg <= cfg_data;
                    REG_DIRTY: dirty_reg <= cfg_data;
                    REG_DELTA: delta_reg <= cfg_data[PCT_W-1:0];
                    REG_ALARM: alarm_reg <= cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept) begin
                        sample_reg <= s_tdata[SAMPLE_W-1:0];
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    old_reg <= valid_reg[wpos_reg] ? rd_data_reg : '0;
                    prod_reg <= DVD_W'(sample_reg - dirty_reg) * DVD_W'(FULL_SCALE);
                    div_sor_reg <= clean_reg - dirty_reg;
                    if (sample_reg >= clean_reg) begin
                        pct_reg   <= FULL_SCALE;
                        state_reg <= S_UPD;
                    end else if (sample_reg <= dirty_reg) begin
                        pct_reg   <= '0;
                        state_reg <= S_UPD;
                    end else begin
                        state_reg <= S_DIV;
                        div_cnt_reg <= PCT_STEPS - 4'd1;
                    end
                end
                S_DIV:
                begin
                    // first step loads the dividend
                    if (div_cnt_reg == PCT_STEPS - 4'd1 && prod_reg != '0) begin
                        div_rem_reg <= prod_reg[DVD_W-1:FIX_W];
                        div_dvd_reg <= prod_reg[FIX_W-1:0];
                        prod_reg    <= '0;
                    end else begin
                        div_rem_reg <= rem_next;
                        div_dvd_reg <= dvd_next;
                        if (div_cnt_reg == 4'd0) begin
                            pct_reg   <= dvd_next;
                            state_reg <= S_UPD;
                        end else begin
                            div_cnt_reg <= div_cnt_reg - 4'd1;
                        end
                    end
                end
                S_UPD:
                begin
                    total_reg <= total_next;
                    valid_reg[wpos_reg] <= 1'b1;
                    if (wpos_reg == AW'(WINDOW_LENGTH - 1)) begin
                        wpos_reg <= '0;
                    end else begin
                        wpos_reg <= wpos_reg + AW'(1);
                    end
                    state_reg <= S_MEAN;
                end
                S_MEAN:
                begin
                    mean_reg  <= mean_calc;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free) begin
                        level_reg     <= mean_reg;
                        digits_reg    <= to_digits(mean_reg);
                        save_reg      <= save_now;
                        alarm_out_reg <= (mean_reg < alarm_reg);
                        if (save_now) begin
                            saved_reg <= mean_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `SPMA_ASSERT_NOW(a_level_range, m_tvalid, m_tdata[6:0] <= PCT_MAX, "level above 100")
    `SPMA_ASSERT_NOW(a_digits_match, m_tvalid, digits_ok, "digits disagree with level")
    `SPMA_ASSERT_NOW(a_div_rem, div_stepping, div_rem_reg < div_sor_reg, "remainder too big")
    `SPMA_ASSERT_NEXT(a_total_bound, state_reg == S_UPD, total_reg <= TOTAL_LIM, "total too large")

endmodule
